FILE: sv/lapt_pkg.sv
// Shared types and constants for the lean AFR protection timer.
package lapt_pkg;

  localparam int DELAY_SCALE_MS = 100;
  localparam int MAP_SCALE_SHIFT = 1;
  localparam int DELAY_LIMIT_W = 15;
  localparam int TIME_W = 32;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_FIXED  = 2'd1,
    MODE_TARGET = 2'd2,
    MODE_NONE   = 2'd3
  } afr_mode_t;

  typedef enum logic [2:0] {
    REG_AFR_MODE       = 3'd0,
    REG_AFR_THRESHOLD  = 3'd1,
    REG_MIN_MAP_HALF   = 3'd2,
    REG_MIN_RPM        = 3'd3,
    REG_MIN_THROTTLE   = 3'd4,
    REG_CUT_DELAY      = 3'd5,
    REG_REACTIVATE_TPS = 3'd6
  } reg_idx_t;

  typedef struct packed {
    afr_mode_t  afr_mode;
    logic [7:0] afr_threshold;
    logic [7:0] min_map_half;
    logic [7:0] min_rpm_hundreds;
    logic [7:0] min_throttle;
    logic [7:0] cut_delay_tenths;
    logic [7:0] reactivate_throttle;
  } cfg_t;

  typedef struct packed {
    logic [9:0]        map_kpa;
    logic [7:0]        rpm_div100;
    logic [7:0]        throttle;
    logic [7:0]        afr_measured;
    logic [7:0]        afr_goal;
    logic [TIME_W-1:0] now_ms;
  } sample_t;

  typedef struct packed {
    logic              latched;
    logic              running;
    logic [TIME_W-1:0] start;
  } state_t;

endpackage

FILE: sv/lapt_eval.sv
// Lean condition check and next timer and latch state for one sample.
module lapt_eval (
  input  lapt_pkg::cfg_t    cfg,
  input  lapt_pkg::state_t  state,
  input  lapt_pkg::sample_t sample,
  output lapt_pkg::state_t  state_next
);

  logic                               map_ok;
  logic                               rpm_ok;
  logic                               tps_ok;
  logic                               afr_hit;
  logic                               lean;
  logic [8:0]                         afr_limit;
  logic [lapt_pkg::DELAY_LIMIT_W-1:0] delay_limit;
  logic [lapt_pkg::TIME_W-1:0]        elapsed;
  logic [lapt_pkg::TIME_W-1:0]        start_eff;

  assign map_ok    = sample.map_kpa >=
                     {1'b0, cfg.min_map_half, {lapt_pkg::MAP_SCALE_SHIFT{1'b0}}};
  assign rpm_ok    = sample.rpm_div100 >= cfg.min_rpm_hundreds;
  assign tps_ok    = sample.throttle >= cfg.min_throttle;
  assign afr_limit = {1'b0, sample.afr_goal} + {1'b0, cfg.afr_threshold};

  always_comb begin
    case (cfg.afr_mode)
      lapt_pkg::MODE_FIXED:  afr_hit = sample.afr_measured >= cfg.afr_threshold;
      lapt_pkg::MODE_TARGET: afr_hit = {1'b0, sample.afr_measured} >= afr_limit;
      default:               afr_hit = 1'b0;
    endcase
  end

  assign lean        = map_ok && rpm_ok && tps_ok && afr_hit;
  assign delay_limit = lapt_pkg::DELAY_LIMIT_W'(cfg.cut_delay_tenths * lapt_pkg::DELAY_SCALE_MS);
  assign start_eff   = state.running ? state.start : sample.now_ms;
  assign elapsed     = sample.now_ms - start_eff;

  always_comb begin
    state_next = state;
    if (cfg.afr_mode == lapt_pkg::MODE_OFF) begin
      state_next = '0;
    end else begin
      if (lean) begin
        state_next.running = 1'b1;
        state_next.start   = start_eff;
        if (elapsed >= lapt_pkg::TIME_W'(delay_limit)) begin
          state_next.latched = 1'b1;
        end
      end else if (state.running) begin
        state_next.running = 1'b0;
        state_next.start   = '0;
      end
      if (state_next.latched && sample.throttle <= cfg.reactivate_throttle) begin
        state_next.latched = 1'b0;
        state_next.running = 1'b0;
      end
    end
  end

endmodule

FILE: sv/lean_afr_protection_timer.sv
// Lean AFR protection timer top level: sample register, evaluation, result register.
//
//   Channel  Handshake                  Payload
//   sample   sample_valid/sample_stall  map_kpa rpm_div100 throttle afr_measured afr_goal now_ms
//   result   result_valid/result_stall  cut_active
//   config   cfg_valid/cfg_ready        cfg_index cfg_data
//
// One sample per cycle while sample_stall is low; a sample waits in the sample register until its result is registered.
// The timer state is updated once per sample as it moves from the sample register
// into the result register, so samples are processed strictly in order.
// Reset clears the configuration, the timer, the latch and both valid flags.
// A stalled result blocks the sample register; sample_stall rises only then.
module lean_afr_protection_timer (
  input  logic        clk,
  input  logic        rst,
  input  logic        sample_valid,
  output logic        sample_stall,
  input  logic [9:0]  map_kpa,
  input  logic [7:0]  rpm_div100,
  input  logic [7:0]  throttle,
  input  logic [7:0]  afr_measured,
  input  logic [7:0]  afr_goal,
  input  logic [31:0] now_ms,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        cut_active,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  lapt_pkg::cfg_t    cfg;
  lapt_pkg::state_t  state;
  lapt_pkg::state_t  state_next;
  lapt_pkg::sample_t s1_sample;
  logic              s1_valid;
  logic              advance;
  logic              take;

  assign cfg_ready    = 1'b1;
  assign advance      = !result_valid || !result_stall;
  assign sample_stall = s1_valid && !advance;
  assign take         = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (lapt_pkg::reg_idx_t'(cfg_index))
        lapt_pkg::REG_AFR_MODE:       cfg.afr_mode <= lapt_pkg::afr_mode_t'(cfg_data[1:0]);
        lapt_pkg::REG_AFR_THRESHOLD:  cfg.afr_threshold <= cfg_data;
        lapt_pkg::REG_MIN_MAP_HALF:   cfg.min_map_half <= cfg_data;
        lapt_pkg::REG_MIN_RPM:        cfg.min_rpm_hundreds <= cfg_data;
        lapt_pkg::REG_MIN_THROTTLE:   cfg.min_throttle <= cfg_data;
        lapt_pkg::REG_CUT_DELAY:      cfg.cut_delay_tenths <= cfg_data;
        lapt_pkg::REG_REACTIVATE_TPS: cfg.reactivate_throttle <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_sample <= '{map_kpa: map_kpa, rpm_div100: rpm_div100, throttle: throttle,
                     afr_measured: afr_measured, afr_goal: afr_goal, now_ms: now_ms};
    end
    if (advance && s1_valid) begin
      cut_active <= state_next.latched;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
      state        <= '0;
    end else begin
      if (advance) begin
        result_valid <= s1_valid;
        if (s1_valid) begin
          state <= state_next;
        end
      end
      if (take) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  lapt_eval u_eval (
    .cfg        (cfg),
    .state      (state),
    .sample     (s1_sample),
    .state_next (state_next)
  );

endmodule

FILE: sv/lapt_checker.sv
// Port-level checks for the lean AFR protection timer, bound to the top level.
module lapt_checker (
  input logic        clk,
  input logic        rst,
  input logic        sample_valid,
  input logic        sample_stall,
  input logic [7:0]  throttle,
  input logic        result_valid,
  input logic        result_stall,
  input logic        cut_active
);

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(cut_active))
    else $error("stalled result changed");

  // Input stalls only when the result register is full and stalled.
  assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> result_valid && result_stall)
    else $error("sample stalled without a stalled result");

  // A closed throttle always clears the cut in the result of that transaction.
  assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall && throttle == 8'd0) ##1 !result_stall
    |=> result_valid && !cut_active)
    else $error("cut reported active at closed throttle");

  // No result is presented right after reset.
  assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind lean_afr_protection_timer lapt_checker u_lapt_checker (.*);
